### src/srlc8_pkg.sv
// ----------------------------------------------------------------------------
// srlc8_pkg
// types, codes and crc-8 helper for the serial register link master
// ----------------------------------------------------------------------------
package srlc8_pkg;

    localparam int unsigned REPLY_LEN = 8;
    localparam logic [3:0]  ECHO_LEN  = 4'd4;
    localparam logic [7:0]  CRC_POLY  = 8'h07;

    localparam logic [1:0] CFG_NODE    = 2'd0;
    localparam logic [1:0] CFG_SYNC    = 2'd1;
    localparam logic [1:0] CFG_SINGLE  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT = 2'd3;

    localparam logic [7:0]  RST_NODE    = 8'd0;
    localparam logic [7:0]  RST_SYNC    = 8'd5;
    localparam logic        RST_SINGLE  = 1'b1;
    localparam logic [15:0] RST_TIMEOUT = 16'd10;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RX    = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BUSY = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RS_OK      = 2'd0,
        RS_CRC     = 2'd1,
        RS_TIMEOUT = 2'd2
    } t_rstat;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  reg_addr;
        logic [3:0]  reg_slot;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [3:0]  done_slot;
        logic [31:0] read_value;
        logic [1:0]  read_status;
    } t_out_item;

    // one byte into the crc, lsb first, crc shifted left
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int j = 0; j < 8; j++) begin
            fb = c[7] ^ b[j];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

### src/srlc8_ram.sv
// ----------------------------------------------------------------------------
// srlc8_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module srlc8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/serial_register_link_crc8_unit.sv
// busy, timeout and first datagram byte appear in the cycle after the item is taken
// a write gives 8 bytes and a read request 4 bytes, one per cycle as the sink takes them
// the final reply byte starts a sweep of the 8-entry reply ram that ends in the done result
// throughput: one item per cycle for single-result items while results are taken; the
// next item enters while the output register holds the previous result only if it is taken
// reset: synchronous active low, config to defaults, no read pending, all slots invalid
// ----------------------------------------------------------------------------
// serial_register_link_crc8_unit
// master side of a single-wire register link with crc-8 datagrams
// ----------------------------------------------------------------------------
module serial_register_link_crc8_unit
    import srlc8_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SLOT_AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RPL_AW  = $clog2(REPLY_LEN);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TX    = 4'b0010,
        S_CHECK = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;
    logic [7:0]  r_node, r_sync;
    logic        r_single;
    logic [15:0] r_timeout;
    logic        r_pend, n_pend;
    logic [3:0]  r_pend_slot, n_pend_slot;
    logic [3:0]  r_rx_cnt, n_rx_cnt;
    logic [15:0] r_elapsed, n_elapsed;
    logic [7:0]  r_frm [0:5];
    logic [7:0]  n_frm [0:5];
    logic [7:0]  r_crc, n_crc;
    logic [2:0]  r_cnt, n_cnt;
    logic [2:0]  r_last_cnt, n_last_cnt;
    logic [3:0]  r_rd_addr, n_rd_addr;
    logic        r_rd_vld;
    logic [2:0]  r_rd_pos;
    logic [31:0] r_val, n_val;
    logic        r_ok, n_ok;
    logic [NUM_SLOTS-1:0] r_slot_valid;

    logic               w_out_free;
    logic               w_acc;
    logic [3:0]         w_skip;
    logic [3:0]         w_idx;
    logic               w_rx_store;
    logic               w_rx_we;
    logic               w_rx_end;
    logic               w_rd_en;
    logic [7:0]         w_rd_data;
    logic               w_fin_go;
    logic               w_slot_we;
    logic [SLOT_AW-1:0] w_slot_addr;
    logic [31:0]        w_slot_rd_data;
    logic               w_last;
    logic [7:0]         w_tx;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_skip     = r_single ? ECHO_LEN : 4'd0;
    assign w_idx      = r_rx_cnt - w_skip;
    assign w_rx_store = w_acc && (i_in_item.opcode == OP_RX) && r_pend && (r_rx_cnt >= w_skip);
    assign w_rx_we    = w_rx_store && !w_idx[3];
    assign w_rx_end   = w_rx_store && (w_idx >= 4'd7);
    assign w_rd_en    = (r_state == S_CHECK) && !r_rd_addr[3];

    assign w_fin_go    = (r_state == S_FIN) && w_out_free;
    assign w_slot_we   = w_fin_go && r_ok;
    assign w_slot_addr = SLOT_AW'(r_pend_slot);

    assign w_last = (r_cnt == r_last_cnt);
    assign w_tx   = w_last ? r_crc : r_frm[0];

    srlc8_ram #(
        .WIDTH (8),
        .DEPTH (REPLY_LEN)
    ) u_reply_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rx_we),
        .i_wr_addr (w_idx[RPL_AW-1:0]),
        .i_wr_data (i_in_item.rx_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr[RPL_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    srlc8_ram #(
        .WIDTH (32),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_addr),
        .i_wr_data (r_val),
        .i_rd_en   (1'b0),
        .i_rd_addr ('0),
        .o_rd_data (w_slot_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_rx_cnt    = r_rx_cnt;
        n_elapsed   = r_elapsed;
        n_frm       = r_frm;
        n_crc       = r_crc;
        n_cnt       = r_cnt;
        n_last_cnt  = r_last_cnt;
        n_rd_addr   = r_rd_addr;
        n_val       = r_val;
        n_ok        = r_ok;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (i_in_item.opcode) inside
                        OP_WRITE, OP_READ: begin
                            if (r_pend || ((i_in_item.opcode == OP_READ) &&
                                           (32'(i_in_item.reg_slot) >= NUM_SLOTS))) begin
                                n_out       = '0;
                                n_out.kind  = KIND_BUSY;
                                n_out_valid = 1'b1;
                            end else begin
                                n_out         = '0;
                                n_out.kind    = KIND_TX;
                                n_out.tx_byte = r_sync;
                                n_out_valid   = 1'b1;
                                n_crc         = crc8_byte(8'h00, r_sync);
                                n_cnt         = 3'd1;
                                n_frm[0]      = r_node;
                                n_frm[2]      = i_in_item.write_data[31:24];
                                n_frm[3]      = i_in_item.write_data[23:16];
                                n_frm[4]      = i_in_item.write_data[15:8];
                                n_frm[5]      = i_in_item.write_data[7:0];
                                n_state       = S_TX;
                                if (i_in_item.opcode == OP_WRITE) begin
                                    n_frm[1]   = {1'b1, i_in_item.reg_addr};
                                    n_last_cnt = 3'd7;
                                end else begin
                                    n_frm[1]    = {1'b0, i_in_item.reg_addr};
                                    n_last_cnt  = 3'd3;
                                    n_pend      = 1'b1;
                                    n_pend_slot = i_in_item.reg_slot;
                                    n_rx_cnt    = 4'd0;
                                    n_elapsed   = 16'd0;
                                end
                            end
                        end
                        OP_RX: begin
                            if (r_pend) begin
                                if (r_rx_cnt < w_skip) begin
                                    n_rx_cnt = r_rx_cnt + 4'd1;
                                end else begin
                                    if (r_rx_cnt != 4'd15) begin
                                        n_rx_cnt = r_rx_cnt + 4'd1;
                                    end
                                    if (w_rx_end) begin
                                        n_pend    = 1'b0;
                                        n_crc     = 8'h00;
                                        n_rd_addr = 4'd0;
                                        n_state   = S_CHECK;
                                    end
                                end
                            end
                        end
                        default: begin
                            if (r_pend) begin
                                if (r_elapsed >= r_timeout) begin
                                    n_pend            = 1'b0;
                                    n_out             = '0;
                                    n_out.kind        = KIND_DONE;
                                    n_out.done_slot   = r_pend_slot;
                                    n_out.read_status = RS_TIMEOUT;
                                    n_out_valid       = 1'b1;
                                end else begin
                                    n_elapsed = r_elapsed + 16'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            S_TX: begin
                if (w_out_free) begin
                    n_out         = '0;
                    n_out.kind    = KIND_TX;
                    n_out.tx_byte = w_tx;
                    n_out.last    = w_last;
                    n_out_valid   = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_crc = crc8_byte(r_crc, r_frm[0]);
                        n_cnt = r_cnt + 3'd1;
                        for (int k = 0; k < 5; k++) begin
                            n_frm[k] = r_frm[k+1];
                        end
                    end
                end
            end
            S_CHECK: begin
                if (w_rd_en) begin
                    n_rd_addr = r_rd_addr + 4'd1;
                end
                if (r_rd_vld) begin
                    if (r_rd_pos == 3'd7) begin
                        n_ok    = (r_crc == w_rd_data);
                        n_state = S_FIN;
                    end else begin
                        n_crc = crc8_byte(r_crc, w_rd_data);
                        if (r_rd_pos >= 3'd3) begin
                            n_val = {r_val[23:0], w_rd_data};
                        end
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out             = '0;
                    n_out.kind        = KIND_DONE;
                    n_out.done_slot   = r_pend_slot;
                    n_out.read_value  = r_ok ? r_val : 32'd0;
                    n_out.read_status = r_ok ? RS_OK : RS_CRC;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_pend_slot  <= 4'd0;
            r_rx_cnt     <= 4'd0;
            r_elapsed    <= 16'd0;
            r_cnt        <= 3'd0;
            r_last_cnt   <= 3'd0;
            r_rd_addr    <= 4'd0;
            r_rd_vld     <= 1'b0;
            r_slot_valid <= '0;
            r_node       <= RST_NODE;
            r_sync       <= RST_SYNC;
            r_single     <= RST_SINGLE;
            r_timeout    <= RST_TIMEOUT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            r_pend_slot <= n_pend_slot;
            r_rx_cnt    <= n_rx_cnt;
            r_elapsed   <= n_elapsed;
            r_cnt       <= n_cnt;
            r_last_cnt  <= n_last_cnt;
            r_rd_addr   <= n_rd_addr;
            r_rd_vld    <= w_rd_en;
            if (w_fin_go) begin
                r_slot_valid[w_slot_addr] <= r_ok;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NODE:    r_node    <= i_cfg_data[7:0];
                    CFG_SYNC:    r_sync    <= i_cfg_data[7:0];
                    CFG_SINGLE:  r_single  <= i_cfg_data[0];
                    CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default:     r_node    <= r_node;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_frm    <= n_frm;
        r_crc    <= n_crc;
        r_val    <= n_val;
        r_ok     <= n_ok;
        r_rd_pos <= r_rd_addr[2:0];
    end

`ifndef NO_ASSERTIONS
    a_pend_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (32'(r_pend_slot) < NUM_SLOTS))
        else $error("pending slot out of range");

    a_fin_from_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_FIN) |-> $past(r_state == S_CHECK))
        else $error("done result without reply sweep");

    a_tx_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX) |-> (r_cnt <= r_last_cnt && r_cnt != 3'd0))
        else $error("datagram byte count beyond frame");

    a_check_idle_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK || r_state == S_FIN) |-> !r_pend)
        else $error("read still pending during reply check");
`endif

endmodule

### tb/sv/serial_register_link_crc8_unit_tb.sv
// ----------------------------------------------------------------------------
// serial_register_link_crc8_unit_tb
// self-checking bench for the crc-8 register link master: every accepted item
// runs through a predictor of the datagram, reply and timeout behavior, and each
// result from the block is checked in order against the predicted queue; a short
// directed pass covers field extremes and corner cases, then random phases send
// mostly well-formed read transactions under several register settings with
// random idling on both channels
// ----------------------------------------------------------------------------
import srlc8_pkg::*;

class reg_link_predictor;
    logic [7:0]  node_addr;
    logic [7:0]  sync_val;
    logic        single_wire;
    logic [15:0] timeout_ms;
    bit          read_pending;
    logic [3:0]  pending_slot;
    logic [3:0]  rx_count;
    logic [7:0]  reply_buf [8];
    logic [15:0] elapsed_ms;
    t_out_item   due_results [$];
    int          n_errors;
    int          n_worked;

    function new();
        node_addr    = RST_NODE;
        sync_val     = RST_SYNC;
        single_wire  = RST_SINGLE;
        timeout_ms   = RST_TIMEOUT;
        read_pending = 1'b0;
        pending_slot = '0;
        rx_count     = '0;
        elapsed_ms   = '0;
        n_errors     = 0;
        n_worked     = 0;
    endfunction

    // crc-8 poly 0x07, init 0, data bits lsb first, register shifted left
    static function logic [7:0] frame_crc(logic [7:0] data_bytes [8], int n);
        logic [7:0] c;
        logic [7:0] b;
        c = 8'h00;
        for (int i = 0; i < n; i++) begin
            b = data_bytes[i];
            for (int j = 0; j < 8; j++) begin
                if (c[7] ^ b[0]) begin
                    c = {c[6:0], 1'b0} ^ CRC_POLY;
                end else begin
                    c = {c[6:0], 1'b0};
                end
                b = b >> 1;
            end
        end
        return c;
    endfunction

    task report(string what, logic [31:0] got_v, logic [31:0] want_v);
        $display("mismatch %s: got %0h, expected %0h", what, got_v, want_v);
        n_errors++;
    endtask

    function void note_config(logic [1:0] index, logic [15:0] value);
        case (index)
            CFG_NODE:    node_addr   = value[7:0];
            CFG_SYNC:    sync_val    = value[7:0];
            CFG_SINGLE:  single_wire = value[0];
            CFG_TIMEOUT: timeout_ms  = value;
            default: ;
        endcase
    endfunction

    function void queue_frame(logic [7:0] frame [8], int n);
        t_out_item r;
        for (int i = 0; i < n; i++) begin
            r         = '0;
            r.kind    = KIND_TX;
            r.tx_byte = frame[i];
            r.last    = (i == n - 1);
            due_results.push_back(r);
        end
    endfunction

    function void note_item(t_in_item it);
        logic [7:0]  frame [8];
        t_out_item   r;
        int unsigned skip;
        int unsigned pos;
        r = '0;
        if (it.opcode == OP_WRITE || it.opcode == OP_READ || read_pending) n_worked++;
        case (it.opcode)
            OP_WRITE, OP_READ: begin
                frame[0] = sync_val;
                frame[1] = node_addr;
                if (read_pending) begin
                    r.kind = KIND_BUSY;
                    due_results.push_back(r);
                end else if (it.opcode == OP_WRITE) begin
                    frame[2] = {1'b1, it.reg_addr};
                    frame[3] = it.write_data[31:24];
                    frame[4] = it.write_data[23:16];
                    frame[5] = it.write_data[15:8];
                    frame[6] = it.write_data[7:0];
                    frame[7] = frame_crc(frame, 7);
                    queue_frame(frame, 8);
                end else begin
                    frame[2] = {1'b0, it.reg_addr};
                    frame[3] = frame_crc(frame, 3);
                    queue_frame(frame, 4);
                    read_pending = 1'b1;
                    pending_slot = it.reg_slot;
                    rx_count     = '0;
                    elapsed_ms   = '0;
                end
            end
            OP_RX: begin
                if (read_pending) begin
                    skip = single_wire ? ECHO_LEN : 0;
                    if (rx_count < skip) begin
                        rx_count++;
                    end else begin
                        pos = rx_count - skip;
                        if (pos < REPLY_LEN) reply_buf[pos] = it.rx_byte;
                        if (rx_count < 15) rx_count++;
                        if (pos >= REPLY_LEN - 1) begin
                            read_pending = 1'b0;
                            r.kind       = KIND_DONE;
                            r.done_slot  = pending_slot;
                            if (frame_crc(reply_buf, 7) != reply_buf[7]) begin
                                r.read_status = RS_CRC;
                            end else begin
                                r.read_status = RS_OK;
                                r.read_value  = {reply_buf[3], reply_buf[4],
                                                 reply_buf[5], reply_buf[6]};
                            end
                            due_results.push_back(r);
                        end
                    end
                end
            end
            default: begin
                if (read_pending) begin
                    if (elapsed_ms >= timeout_ms) begin
                        read_pending  = 1'b0;
                        r.kind        = KIND_DONE;
                        r.done_slot   = pending_slot;
                        r.read_status = RS_TIMEOUT;
                        due_results.push_back(r);
                    end else begin
                        elapsed_ms++;
                    end
                end
            end
        endcase
    endfunction

    task check_result(t_out_item got);
        t_out_item want;
        if (due_results.size() == 0) begin
            report("unexpected result kind", got.kind, '0);
            return;
        end
        want = due_results.pop_front();
        if (got.kind !== want.kind) report("kind", got.kind, want.kind);
        if (got.tx_byte !== want.tx_byte) report("tx_byte", got.tx_byte, want.tx_byte);
        if (got.last !== want.last) report("last", got.last, want.last);
        if (got.done_slot !== want.done_slot) report("done_slot", got.done_slot, want.done_slot);
        if (got.read_value !== want.read_value) report("read_value", got.read_value, want.read_value);
        if (got.read_status !== want.read_status) begin
            report("read_status", got.read_status, want.read_status);
        end
    endtask
endclass

module serial_register_link_crc8_unit_tb;

    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 60;

    typedef enum int {REPLY_GOOD, REPLY_BAD_CRC, REPLY_CUT} t_reply_shape;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_NODE;
    logic [15:0] i_cfg_data  = '0;

    bit                calm = 1'b0;
    reg_link_predictor link_pred;

    serial_register_link_crc8_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) link_pred.check_result(o_out_item);
        i_out_ready <= calm || ($urandom_range(99) >= 34);
    end

    function automatic t_in_item make_item(t_op op, logic [6:0] addr, logic [3:0] slot,
                                           logic [31:0] data, logic [7:0] rxb);
        t_in_item it;
        it.opcode     = op;
        it.reg_addr   = addr;
        it.reg_slot   = slot;
        it.write_data = data;
        it.rx_byte    = rxb;
        return it;
    endfunction

    function automatic t_in_item rand_item(t_op op);
        return make_item(op, 7'($urandom), 4'($urandom), $urandom, 8'($urandom));
    endfunction

    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        link_pred.note_item(it);
    endtask

    task automatic send_rx(logic [7:0] b);
        send_item(make_item(OP_RX, 7'($urandom), 4'($urandom), $urandom, b));
    endtask

    task automatic wait_results_done();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (link_pred.due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        link_pred.note_config(index, value);
    endtask

    task automatic apply_settings(logic [7:0] node, logic [7:0] sync, logic single,
                                  logic [15:0] tmo);
        write_reg(CFG_NODE, {8'($urandom), node});
        write_reg(CFG_SYNC, {8'($urandom), sync});
        write_reg(CFG_SINGLE, {15'($urandom), single});
        write_reg(CFG_TIMEOUT, tmo);
        i_cfg_valid <= 1'b0;
    endtask

    // read request, echo, reply; stray ticks and busy requests mixed in
    task automatic run_read(t_reply_shape shape);
        logic [7:0]  reply [8];
        int unsigned skip;
        int unsigned n_bytes;
        int unsigned n_ticks;
        send_item(rand_item(OP_READ));
        skip = link_pred.single_wire ? ECHO_LEN : 0;
        for (int i = 0; i < 8; i++) reply[i] = 8'($urandom);
        reply[7] = link_pred.frame_crc(reply, 7);
        if (shape == REPLY_BAD_CRC) reply[7] ^= 8'($urandom_range(1, 255));
        n_bytes = skip + REPLY_LEN;
        if (shape == REPLY_CUT) n_bytes = $urandom_range(0, n_bytes - 1);
        n_ticks = 0;
        for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(9) == 0) begin
                send_item(rand_item($urandom_range(1) ? OP_WRITE : OP_READ));
            end
            if ($urandom_range(9) == 0 && n_ticks < link_pred.timeout_ms) begin
                send_item(rand_item(OP_TICK));
                n_ticks++;
            end
            send_rx(i < skip ? 8'($urandom) : reply[i - skip]);
        end
        if (shape == REPLY_CUT) begin
            for (int k = n_ticks; k <= link_pred.timeout_ms; k++) send_item(rand_item(OP_TICK));
        end
    endtask

    task automatic run_phase(int n);
        int upto;
        int pick;
        upto = link_pred.n_worked + n;
        while (link_pred.n_worked < upto) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                send_item(rand_item(OP_WRITE));
            end else if (pick < 66) begin
                run_read(REPLY_GOOD);
            end else if (pick < 76) begin
                run_read(REPLY_BAD_CRC);
            end else if (pick < 86) begin
                run_read(link_pred.timeout_ms <= 40 ? REPLY_CUT : REPLY_GOOD);
            end else if (pick < 97) begin
                send_item(rand_item(t_op'($urandom_range(3))));
            end else begin
                wait_results_done();
            end
        end
        while (link_pred.read_pending) send_rx(8'($urandom));
        wait_results_done();
    endtask

    initial begin
        logic [7:0] reply [8];
        link_pred = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, idle byte and tick, busy requests
        send_item(make_item(OP_WRITE, 7'h00, 4'h0, 32'h0000_0000, 8'h00));
        send_item(make_item(OP_WRITE, 7'h7f, 4'hf, 32'hffff_ffff, 8'hff));
        send_rx(8'hff);
        send_item(rand_item(OP_TICK));
        send_item(make_item(OP_READ, 7'h7f, 4'hf, 32'hffff_ffff, 8'hff));
        send_item(rand_item(OP_WRITE));
        send_item(rand_item(OP_READ));
        send_item(rand_item(OP_TICK));
        for (int i = 0; i < 4; i++) send_rx(8'($urandom));
        reply = '{8'h05, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'h01, 8'h00};
        reply[7] = link_pred.frame_crc(reply, 7);
        foreach (reply[i]) send_rx(reply[i]);
        wait_results_done();

        // no echo, zero timeout: first tick times out, then a bad crc reply
        apply_settings(8'hff, 8'hff, 1'b0, 16'h0000);
        send_item(make_item(OP_READ, 7'h00, 4'h0, 32'h0000_0000, 8'h00));
        send_item(rand_item(OP_TICK));
        send_item(rand_item(OP_WRITE));
        send_item(rand_item(OP_READ));
        reply[7] = ~reply[7];
        foreach (reply[i]) send_rx(reply[i]);
        wait_results_done();

        apply_settings(8'h00, 8'h00, 1'b1, 16'd1);
        run_phase(PHASE_ITEMS);
        apply_settings(8'($urandom), 8'($urandom), 1'b0, 16'hffff);
        run_phase(PHASE_ITEMS);
        calm = 1'b1;
        apply_settings(8'($urandom), 8'($urandom), 1'b1, 16'($urandom_range(2, 12)));
        run_phase(PHASE_ITEMS);
        calm = 1'b0;
        apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom_range(0, 30)));
        run_phase(PHASE_ITEMS);
        apply_settings(8'hff, 8'hff, 1'b1, 16'd5);
        run_phase(PHASE_ITEMS);
        apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom_range(1, 20)));
        run_phase(PHASE_ITEMS);

        if (link_pred.due_results.size() != 0) begin
            link_pred.report("results never delivered", '0, link_pred.due_results.size());
        end
        if (link_pred.n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
src/srlc8_pkg.sv
src/srlc8_ram.sv
src/serial_register_link_crc8_unit.sv
tb/sv/serial_register_link_crc8_unit_tb.sv
